// File: src/mcg_pkg.sv
// shared types, widths and constants of the metronome click generator
package mcg_pkg;

   localparam int CLICK_DEPTH_DEF = 4096;
   localparam int NUM_SOUNDS      = 3;

   localparam int FRAME_W   = 24;
   localparam int SAMPLE_W  = 16;
   localparam int IDX_W     = 5;
   localparam int TEMPO_W   = 9;
   localparam int SUBDIV_W  = 5;
   localparam int BAR_W     = 5;
   localparam int RATE_W    = 18;
   localparam int LEN_W     = 13;
   localparam int WADDR_W   = 12;
   localparam int DEN_W     = TEMPO_W + SUBDIV_W;
   localparam int DIV_STEPS = FRAME_W;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = RATE_W;

   localparam int REQ_W  = 32;
   localparam int RSP_W  = 32;
   localparam int KIND_W = 2;

   // result word layout
   localparam int RSP_SAMPLE_LSB  = 0;
   localparam int RSP_CHANGED_BIT = RSP_SAMPLE_LSB + SAMPLE_W;
   localparam int RSP_BEAT_LSB    = RSP_CHANGED_BIT + 1;
   localparam int RSP_CLICK_LSB   = RSP_BEAT_LSB + IDX_W;
   localparam int RSP_USED_W      = RSP_CLICK_LSB + IDX_W;

   localparam int SECONDS_PER_MIN = 60;

   localparam logic [TEMPO_W-1:0]  RESET_TEMPO  = TEMPO_W'(120);
   localparam logic [SUBDIV_W-1:0] RESET_SUBDIV = SUBDIV_W'(1);
   localparam logic [BAR_W-1:0]    RESET_BAR    = BAR_W'(4);
   localparam logic [RATE_W-1:0]   RESET_RATE   = RATE_W'(44100);
   localparam logic [FRAME_W-1:0]  RESET_PERIOD =
      FRAME_W'((44100 * SECONDS_PER_MIN) / (120 * 1));

   typedef enum logic [1:0] {
      KIND_TICK,
      KIND_STOP,
      KIND_START,
      KIND_WRITE
   } kind_type;

   typedef enum logic [1:0] {
      SND_HIGH,
      SND_MEDIUM,
      SND_LOW
   } sound_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEMPO,
      CSR_SUBDIV,
      CSR_BAR,
      CSR_RATE,
      CSR_HIGH_LEN,
      CSR_MEDIUM_LEN,
      CSR_LOW_LEN
   } csr_type;

   // per-item outcome of the counter logic
   typedef struct packed {
      logic             play;
      logic             changed;
      logic [IDX_W-1:0] beat;
      logic [IDX_W-1:0] click;
   } step_type;

endpackage

// File: src/mcg_period_div.sv
// restoring divider for the click period, one quotient bit per cycle
module mcg_period_div import mcg_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                restart,
   input  logic [RATE_W-1:0]   rate,
   input  logic [TEMPO_W-1:0]  tempo,
   input  logic [SUBDIV_W-1:0] subdiv,
   output logic                busy,
   output logic [FRAME_W-1:0]  quotient
);

   localparam int CNT_W = $clog2(DIV_STEPS + 1);

   logic                pend_ff, pend_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [FRAME_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]    den_ff, den_in;
   logic [DEN_W-1:0]    rem_ff, rem_in;
   logic [DEN_W:0]      rem_shift;
   logic [FRAME_W-1:0]  num;
   logic [TEMPO_W-1:0]  tempo_nz;
   logic [SUBDIV_W-1:0] subdiv_nz;

   // zero divisors act as one
   assign tempo_nz  = (tempo == '0) ? TEMPO_W'(1) : tempo;
   assign subdiv_nz = (subdiv == '0) ? SUBDIV_W'(1) : subdiv;
   assign num       = FRAME_W'(rate) * FRAME_W'(SECONDS_PER_MIN);
   assign rem_shift = {rem_ff, quo_ff[FRAME_W-1]};

   always_comb begin
      pend_in = restart;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      if (pend_ff) begin
         quo_in = num;
         den_in = DEN_W'(tempo_nz) * DEN_W'(subdiv_nz);
         rem_in = '0;
         cnt_in = CNT_W'(DIV_STEPS);
      end else if (cnt_ff != '0) begin
         if (rem_shift >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(rem_shift - {1'b0, den_ff});
            quo_in = {quo_ff[FRAME_W-2:0], 1'b1};
         end else begin
            rem_in = DEN_W'(rem_shift);
            quo_in = {quo_ff[FRAME_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b1;
         cnt_ff  <= '0;
      end else begin
         pend_ff <= pend_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign busy     = restart || pend_ff || (cnt_ff != '0);
   assign quotient = quo_ff;

endmodule

// File: src/mcg_wave_mem.sv
// waveform store, one write and one registered read port
module mcg_wave_mem import mcg_pkg::*; #(
   parameter int ENTRIES = NUM_SOUNDS * CLICK_DEPTH_DEF,
   parameter int AW      = $clog2(NUM_SOUNDS * CLICK_DEPTH_DEF)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  logic [SAMPLE_W-1:0] wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output logic [SAMPLE_W-1:0] rd_data
);

   logic [SAMPLE_W-1:0] mem [ENTRIES];
   logic [SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/mcg_beat_ctrl.sv
// frame, click and beat counters with the sound choice and period latch
module mcg_beat_ctrl import mcg_pkg::*; #(
   parameter int CLICK_DEPTH = CLICK_DEPTH_DEF,
   parameter int AW          = $clog2(NUM_SOUNDS * CLICK_DEPTH_DEF),
   parameter int IW          = $clog2(CLICK_DEPTH_DEF)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  kind_type            kind,
   input  logic                hold,
   input  logic [SUBDIV_W-1:0] subdiv,
   input  logic [BAR_W-1:0]    bar,
   input  logic [LEN_W-1:0]    high_len,
   input  logic [LEN_W-1:0]    medium_len,
   input  logic [LEN_W-1:0]    low_len,
   input  logic [FRAME_W-1:0]  period,
   output step_type            step,
   output logic [AW-1:0]       rd_addr
);

   logic [FRAME_W-1:0]  frame_ff, frame_in;
   logic [FRAME_W-1:0]  period_ff, period_in;
   logic [IDX_W-1:0]    click_ff, click_in;
   logic [IDX_W-1:0]    beat_ff, beat_in;
   sound_type           sound_ff, sound_in;

   logic [SUBDIV_W-1:0] subdiv_nz;
   logic [BAR_W-1:0]    bar_nz;
   logic [LEN_W-1:0]    len_sel;
   logic [AW-1:0]       base;
   logic [FRAME_W-1:0]  frame_inc;
   logic                play;
   logic                changed;

   assign subdiv_nz = (subdiv == '0) ? SUBDIV_W'(1) : subdiv;
   assign bar_nz    = (bar == '0) ? BAR_W'(1) : bar;
   assign frame_inc = frame_ff + 1'b1;

   always_comb begin
      case (sound_ff)
         SND_HIGH: begin
            len_sel = high_len;
            base    = '0;
         end
         SND_MEDIUM: begin
            len_sel = medium_len;
            base    = AW'(CLICK_DEPTH);
         end
         default: begin
            len_sel = low_len;
            base    = AW'(2 * CLICK_DEPTH);
         end
      endcase
   end

   // lengths past the store depth act as the depth
   assign play    = (frame_ff < FRAME_W'(len_sel)) && (frame_ff < FRAME_W'(CLICK_DEPTH));
   assign rd_addr = base + AW'(frame_ff[IW-1:0]);

   always_comb begin
      frame_in  = frame_ff;
      period_in = period_ff;
      click_in  = click_ff;
      beat_in   = beat_ff;
      sound_in  = sound_ff;
      changed   = 1'b0;
      step.play = 1'b0;
      if (accept) begin
         case (kind)
            KIND_TICK: begin
               if (beat_ff != '0 && !hold) begin
                  step.play = play;
                  frame_in  = frame_inc;
                  // a shrunken period ends the click as soon as it is reached
                  if (frame_inc >= period_ff) begin
                     frame_in = '0;
                     if (IDX_W'(click_ff) >= IDX_W'(subdiv_nz)) begin
                        click_in = IDX_W'(1);
                        beat_in  = (IDX_W'(beat_ff) >= IDX_W'(bar_nz)) ?
                                   IDX_W'(1) : beat_ff + 1'b1;
                        changed  = 1'b1;
                     end else begin
                        click_in = click_ff + 1'b1;
                     end
                     if (click_in != IDX_W'(1)) begin
                        sound_in = SND_LOW;
                     end else if (beat_in == IDX_W'(1)) begin
                        sound_in = SND_HIGH;
                     end else begin
                        sound_in = SND_MEDIUM;
                     end
                     period_in = period;
                  end
               end
            end
            KIND_STOP, KIND_START: begin
               frame_in  = '0;
               click_in  = IDX_W'(1);
               beat_in   = (kind == KIND_START) ? IDX_W'(1) : '0;
               sound_in  = SND_HIGH;
               changed   = 1'b1;
               period_in = period;
            end
            default: begin
            end
         endcase
      end
      step.changed = changed;
      step.beat    = beat_in;
      step.click   = click_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff  <= '0;
         period_ff <= RESET_PERIOD;
         click_ff  <= IDX_W'(1);
         beat_ff   <= '0;
         sound_ff  <= SND_HIGH;
      end else begin
         frame_ff  <= frame_in;
         period_ff <= period_in;
         click_ff  <= click_in;
         beat_ff   <= beat_in;
         sound_ff  <= sound_in;
      end
   end

endmodule

// File: src/metronome_click_generator_top.sv
// metronome click generator: one result per item, through stage 1 and the output register
// throughput: one item per cycle when the divider is idle and the output is free; results
// held in an output register under backpressure; period divider (sample_rate*60 /
// tempo*subdiv) runs after reset and after every csr write, req_tready is low meanwhile
// reset is synchronous and active high; the waveform store is not cleared, no clearing pass
// stopped at reset: beat 0, click 1, high sound, period from reset registers
module metronome_click_generator_top import mcg_pkg::*; #(
   parameter int CLICK_DEPTH = CLICK_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // item input
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,  // hold, wave_select[1:0], wave_address[11:0],
                                             // wave_value[15:0], zero fill
   input  logic [KIND_W-1:0]     req_tuser,  // kind[1:0]
   // result output
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,  // sample[15:0], beat_changed, beat_number[4:0],
                                             // click_number[4:0], zero fill
   // register writes
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ENTRIES = NUM_SOUNDS * CLICK_DEPTH;
   localparam int AW      = $clog2(ENTRIES);
   localparam int IW      = $clog2(CLICK_DEPTH);

   // configuration registers
   logic [TEMPO_W-1:0]  tempo_ff, tempo_in;
   logic [SUBDIV_W-1:0] subdiv_ff, subdiv_in;
   logic [BAR_W-1:0]    bar_ff, bar_in;
   logic [RATE_W-1:0]   rate_ff, rate_in;
   logic [LEN_W-1:0]    high_len_ff, high_len_in;
   logic [LEN_W-1:0]    medium_len_ff, medium_len_in;
   logic [LEN_W-1:0]    low_len_ff, low_len_in;

   // input fields
   kind_type             kind;
   logic                 hold;
   logic [1:0]           wave_select;
   logic [WADDR_W-1:0]   wave_address;
   logic [SAMPLE_W-1:0]  wave_value;

   // pipeline
   logic                 accept;
   logic                 div_busy;
   logic [FRAME_W-1:0]   div_quotient;
   step_type             step;
   logic [AW-1:0]        rd_addr;
   logic [SAMPLE_W-1:0]  rd_data;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [AW-1:0]        wr_base;

   logic                 s1_valid_ff, s1_valid_in;
   step_type             s1_step_ff, s1_step_in;
   logic                 out_valid_ff, out_valid_in;
   step_type             out_step_ff, out_step_in;
   logic [SAMPLE_W-1:0]  out_sample_ff, out_sample_in;
   logic                 out_free;
   logic                 s1_move;

   // ---- register file, to be written only while idle; the block itself does not enforce it
   always_comb begin
      tempo_in      = tempo_ff;
      subdiv_in     = subdiv_ff;
      bar_in        = bar_ff;
      rate_in       = rate_ff;
      high_len_in   = high_len_ff;
      medium_len_in = medium_len_ff;
      low_len_in    = low_len_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TEMPO:      tempo_in      = csr_wdata[TEMPO_W-1:0];
            CSR_SUBDIV:     subdiv_in     = csr_wdata[SUBDIV_W-1:0];
            CSR_BAR:        bar_in        = csr_wdata[BAR_W-1:0];
            CSR_RATE:       rate_in       = csr_wdata[RATE_W-1:0];
            CSR_HIGH_LEN:   high_len_in   = csr_wdata[LEN_W-1:0];
            CSR_MEDIUM_LEN: medium_len_in = csr_wdata[LEN_W-1:0];
            CSR_LOW_LEN:    low_len_in    = csr_wdata[LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tempo_ff      <= RESET_TEMPO;
         subdiv_ff     <= RESET_SUBDIV;
         bar_ff        <= RESET_BAR;
         rate_ff       <= RESET_RATE;
         high_len_ff   <= '0;
         medium_len_ff <= '0;
         low_len_ff    <= '0;
      end else begin
         tempo_ff      <= tempo_in;
         subdiv_ff     <= subdiv_in;
         bar_ff        <= bar_in;
         rate_ff       <= rate_in;
         high_len_ff   <= high_len_in;
         medium_len_ff <= medium_len_in;
         low_len_ff    <= low_len_in;
      end
   end

   // ---- field unpack
   assign kind         = kind_type'(req_tuser);
   assign hold         = req_tdata[0];
   assign wave_select  = req_tdata[2:1];
   assign wave_address = req_tdata[14:3];
   assign wave_value   = req_tdata[30:15];

   // ---- handshake: stage 1 waits for read data, output register parts the sides
   assign out_free   = !out_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && out_free;
   assign req_tready = !div_busy && (!s1_valid_ff || out_free);
   assign accept     = req_tvalid && req_tready;

   // period is recomputed after every register write, while items are held off
   mcg_period_div u_div (
      .clock    (clock),
      .reset    (reset),
      .restart  (csr_we),
      .rate     (rate_ff),
      .tempo    (tempo_ff),
      .subdiv   (subdiv_ff),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   mcg_beat_ctrl #(
      .CLICK_DEPTH (CLICK_DEPTH),
      .AW          (AW),
      .IW          (IW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .kind       (kind),
      .hold       (hold),
      .subdiv     (subdiv_ff),
      .bar        (bar_ff),
      .high_len   (high_len_ff),
      .medium_len (medium_len_ff),
      .low_len    (low_len_ff),
      .period     (div_quotient),
      .step       (step),
      .rd_addr    (rd_addr)
   );

   // waveform write: bad selector or address past the depth is dropped
   always_comb begin
      case (wave_select)
         2'd0:    wr_base = '0;
         2'd1:    wr_base = AW'(CLICK_DEPTH);
         default: wr_base = AW'(2 * CLICK_DEPTH);
      endcase
   end

   assign wr_addr = wr_base + AW'(wave_address);
   assign wr_en   = accept && (kind == KIND_WRITE) && (wave_select != 2'd3) &&
                    (32'(wave_address) < CLICK_DEPTH);

   // a write accepted ahead of a read lands before the read samples the array
   mcg_wave_mem #(
      .ENTRIES (ENTRIES),
      .AW      (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wave_value),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ---- stage 1 and output register
   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_step_in    = s1_step_ff;
      out_valid_in  = out_valid_ff;
      out_step_in   = out_step_ff;
      out_sample_in = out_sample_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (s1_move) begin
         s1_valid_in   = 1'b0;
         out_valid_in  = 1'b1;
         out_step_in   = s1_step_ff;
         // silence when past the click length, stopped, held or not a tick
         out_sample_in = s1_step_ff.play ? rd_data : '0;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_step_in  = step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      s1_step_ff    <= s1_step_in;
      out_step_ff   <= out_step_in;
      out_sample_ff <= out_sample_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_W - RSP_USED_W)'(0), out_step_ff.click, out_step_ff.beat,
                        out_step_ff.changed, out_sample_ff};

endmodule

// File: src/mcg_checker.sv
// port-level checks for the click generator and their binding
module mcg_checker import mcg_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   logic [SAMPLE_W-1:0] sample;
   logic                changed;
   logic [IDX_W-1:0]    beat;
   logic [IDX_W-1:0]    click;

   assign sample  = rsp_tdata[RSP_SAMPLE_LSB +: SAMPLE_W];
   assign changed = rsp_tdata[RSP_CHANGED_BIT];
   assign beat    = rsp_tdata[RSP_BEAT_LSB +: IDX_W];
   assign click   = rsp_tdata[RSP_CLICK_LSB +: IDX_W];

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // click numbering starts at one
   a_click_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> click != '0)
      else $error("click number zero");

   // a beat change always restarts the click count
   a_change_first_click: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && changed |-> click == IDX_W'(1))
      else $error("beat changed without click one");

   // stopped means silence
   a_stopped_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && beat == '0 |-> sample == '0)
      else $error("sound while stopped");

endmodule

bind metronome_click_generator_top mcg_checker u_mcg_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
